### design/erc_rtt_pkg.sv
// Package: shared types, codes and constants of the echo reply checker.
`timescale 1ns / 1ps

package erc_rtt_pkg;

    // Largest echo message length that the checker will honour.
    localparam logic [15:0] MAX_MESSAGE_BYTES = 16'd32768;
    localparam logic [15:0] MIN_MESSAGE_BYTES = 16'd16;

    localparam logic [31:0] USEC_PER_SEC   = 32'd1000000;
    localparam logic [31:0] TRIP_MIN_RESET = 32'd999999999;
    localparam logic [15:0] LENGTH_RESET   = 16'd56;

    // Configuration register indexes.
    localparam logic CFG_ECHO_IDENT  = 1'b0;
    localparam logic CFG_ICMP_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FOREIGN = 2'd1,
        STAT_BADDATA = 2'd2,
        STAT_SHORT   = 2'd3
    } status_t;

    // What the parser hands on when the last byte of a packet goes through.
    typedef struct packed {
        status_t     status;
        logic [15:0] sequence_number;
        logic [31:0] arrival_sec;
        logic [19:0] arrival_usec;
        logic [31:0] stamp_sec;
        logic [31:0] stamp_usec;
    } pkt_result_t;

    // Clamp the configured length into the supported range.
    function automatic logic [15:0] used_length(input logic [15:0] n);
        logic [15:0] r;
        r = n;
        if (r < MIN_MESSAGE_BYTES) r = MIN_MESSAGE_BYTES;
        if (r > MAX_MESSAGE_BYTES) r = MAX_MESSAGE_BYTES;
        return r;
    endfunction

endpackage

### design/erc_rtt_parser.sv
// Byte parser: tracks position in the packet and collects the echo header fields.
`timescale 1ns / 1ps

module erc_rtt_parser (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,
    input  logic [31:0]               arrival_sec,
    input  logic [19:0]               arrival_usec,
    input  logic [15:0]               echo_ident,
    input  logic [15:0]               icmp_length,
    output erc_rtt_pkg::pkt_result_t  result
);
    import erc_rtt_pkg::*;

    logic [15:0] byte_position_reg, byte_position_next;
    logic [5:0]  message_offset_reg, message_offset_next;
    logic [15:0] ident_seen_reg, ident_seen_next;
    logic [15:0] sequence_seen_reg, sequence_seen_next;
    logic [31:0] stamp_seconds_reg, stamp_seconds_next;
    logic [31:0] stamp_micros_reg, stamp_micros_next;
    logic [31:0] arrival_seconds_held_reg, arrival_seconds_held_next;
    logic [19:0] arrival_micros_held_reg, arrival_micros_held_next;
    logic        payload_bad_reg, payload_bad_next;

    logic        first;
    logic [15:0] len;
    logic [15:0] msg_pos;
    logic        in_msg;
    logic [16:0] pos_plus_one;
    logic [16:0] got;
    status_t     status;

    always_comb begin
        first = (byte_position_reg == 16'd0);
        len   = used_length(icmp_length);

        // The first byte restarts the packet and samples the arrival time.
        message_offset_next       = first ? {data_byte[3:0], 2'b00} : message_offset_reg;
        ident_seen_next           = first ? 16'd0 : ident_seen_reg;
        sequence_seen_next        = first ? 16'd0 : sequence_seen_reg;
        stamp_seconds_next        = first ? 32'd0 : stamp_seconds_reg;
        stamp_micros_next         = first ? 32'd0 : stamp_micros_reg;
        payload_bad_next          = first ? 1'b0 : payload_bad_reg;
        arrival_seconds_held_next = first ? arrival_sec : arrival_seconds_held_reg;
        arrival_micros_held_next  = first ? arrival_usec : arrival_micros_held_reg;

        in_msg  = (byte_position_reg >= {10'd0, message_offset_next});
        msg_pos = byte_position_reg - {10'd0, message_offset_next};

        if (in_msg) begin
            if (msg_pos == 16'd4 || msg_pos == 16'd5) begin
                ident_seen_next = {ident_seen_next[7:0], data_byte};
            end else if (msg_pos == 16'd6 || msg_pos == 16'd7) begin
                sequence_seen_next = {sequence_seen_next[7:0], data_byte};
            end else if (msg_pos >= 16'd8 && msg_pos < 16'd12) begin
                stamp_seconds_next = {stamp_seconds_next[23:0], data_byte};
            end else if (msg_pos >= 16'd12 && msg_pos < 16'd16) begin
                stamp_micros_next = {stamp_micros_next[23:0], data_byte};
            end else if (msg_pos >= 16'd16 && msg_pos < len
                         && data_byte != msg_pos[7:0]) begin
                payload_bad_next = 1'b1;
            end
        end

        // Saturate within a packet, restart after its last byte.
        if (last_byte) begin
            byte_position_next = 16'd0;
        end else if (byte_position_reg != 16'hFFFF) begin
            byte_position_next = byte_position_reg + 16'd1;
        end else begin
            byte_position_next = byte_position_reg;
        end

        pos_plus_one = {1'b0, byte_position_reg} + 17'd1;
        got = (pos_plus_one > {11'd0, message_offset_next})
            ? pos_plus_one - {11'd0, message_offset_next} : 17'd0;

        if (got < {1'b0, len}) begin
            status = STAT_SHORT;
        end else if (ident_seen_next != echo_ident) begin
            status = STAT_FOREIGN;
        end else if (payload_bad_next) begin
            status = STAT_BADDATA;
        end else begin
            status = STAT_OK;
        end

        result.status          = status;
        result.sequence_number = sequence_seen_next;
        result.arrival_sec     = arrival_seconds_held_next;
        result.arrival_usec    = arrival_micros_held_next;
        result.stamp_sec       = stamp_seconds_next;
        result.stamp_usec      = stamp_micros_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg        <= 16'd0;
            message_offset_reg       <= 6'd0;
            ident_seen_reg           <= 16'd0;
            sequence_seen_reg        <= 16'd0;
            stamp_seconds_reg        <= 32'd0;
            stamp_micros_reg         <= 32'd0;
            arrival_seconds_held_reg <= 32'd0;
            arrival_micros_held_reg  <= 20'd0;
            payload_bad_reg          <= 1'b0;
        end else if (step) begin
            byte_position_reg        <= byte_position_next;
            message_offset_reg       <= message_offset_next;
            ident_seen_reg           <= ident_seen_next;
            sequence_seen_reg        <= sequence_seen_next;
            stamp_seconds_reg        <= stamp_seconds_next;
            stamp_micros_reg         <= stamp_micros_next;
            arrival_seconds_held_reg <= arrival_seconds_held_next;
            arrival_micros_held_reg  <= arrival_micros_held_next;
            payload_bad_reg          <= payload_bad_next;
        end
    end

endmodule

### design/echo_reply_checker_rtt_stats_unit.sv
// Top level: echo reply checker with round-trip time statistics.
`timescale 1ns / 1ps

// Takes a received IP packet one byte per item on the slave stream and gives one
// result item on the master stream for each packet, on its last byte. The header
// length nibble of the first byte locates the echo message; the identifier,
// sequence number and big-endian send timestamp are collected from it, and the
// payload from offset 16 up to the configured length is checked against its
// offset mod 256. An accepted reply yields the round trip in microseconds and
// updates the count, minimum, maximum and sum, which the result item carries as
// they stand after that packet. One byte is taken every clock cycle unless a last
// byte waits in the input register for room for its result; the rate is set by the
// parser step on the input register. A result passes through the input register,
// result capture, timestamp subtraction, multiply by one million and statistics
// update. Stalls on the master side back up through the result stages only as far
// as they are occupied, so bytes keep flowing while a result waits. The user must
// write Configuration through cfg_wr_en / cfg_index / cfg_wdata only while idle, which the block does not enforce.

module echo_reply_checker_rtt_stats_unit (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata,

    input  logic         s_tvalid,
    output logic         s_tready,
    // data_byte [7:0], arrival_sec [39:8], arrival_usec [59:40], zero [63:60]
    input  logic [63:0]  s_tdata,
    input  logic         s_tlast,

    output logic         m_tvalid,
    input  logic         m_tready,
    // trip_time [31:0], sequence_number [47:32], received_count [79:48],
    // rtt_min [111:80], rtt_max [143:112], rtt_sum [191:144]
    output logic [191:0] m_tdata,
    // status [1:0]
    output logic [1:0]   m_tuser
);
    import erc_rtt_pkg::*;

    // Configuration registers.
    logic [15:0] echo_ident_reg;
    logic [15:0] icmp_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_ident_reg  <= 16'd0;
            icmp_length_reg <= LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ECHO_IDENT:  echo_ident_reg  <= cfg_wdata;
                CFG_ICMP_LENGTH: icmp_length_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Stage enables: each stage advances when empty or when the one after it moves.
    logic o_valid_reg, d_valid_reg, c_valid_reg, b_valid_reg, a_valid_reg;
    logic o_adv, d_adv, c_adv, b_adv, a_step, s_accept;

    assign o_adv = !o_valid_reg || m_tready;
    assign d_adv = !d_valid_reg || o_adv;
    assign c_adv = !c_valid_reg || d_adv;
    assign b_adv = !b_valid_reg || c_adv;

    // Input register: hold the accepted item until the parser steps on it.
    logic        a_last_reg;
    logic [7:0]  a_data_reg;
    logic [31:0] a_sec_reg;
    logic [19:0] a_usec_reg;

    // A non-last byte always steps; a last byte needs room for its result.
    assign a_step   = a_valid_reg && (!a_last_reg || b_adv);
    assign s_tready = !a_valid_reg || a_step;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_step) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_data_reg <= s_tdata[7:0];
            a_sec_reg  <= s_tdata[39:8];
            a_usec_reg <= s_tdata[59:40];
            a_last_reg <= s_tlast;
        end
    end

    pkt_result_t parse_result;

    erc_rtt_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (a_step),
        .data_byte    (a_data_reg),
        .last_byte    (a_last_reg),
        .arrival_sec  (a_sec_reg),
        .arrival_usec (a_usec_reg),
        .echo_ident   (echo_ident_reg),
        .icmp_length  (icmp_length_reg),
        .result       (parse_result)
    );

    // Stage B: capture the packet record on its last byte.
    pkt_result_t b_rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_adv) begin
            b_valid_reg <= a_step && a_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            b_rec_reg <= parse_result;
        end
    end

    // Stage C: timeval subtraction, borrowing a second when microseconds go negative.
    logic [32:0] du_wide;
    logic        borrow;
    logic [31:0] ds_next, du_next;
    logic [31:0] c_ds_reg, c_du_reg;
    status_t     c_status_reg;
    logic [15:0] c_seq_reg;

    always_comb begin
        du_wide = {13'd0, b_rec_reg.arrival_usec} - {1'b0, b_rec_reg.stamp_usec};
        borrow  = du_wide[32];
        ds_next = b_rec_reg.arrival_sec - b_rec_reg.stamp_sec - {31'd0, borrow};
        du_next = du_wide[31:0] + (borrow ? USEC_PER_SEC : 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_adv) begin
            c_ds_reg     <= ds_next;
            c_du_reg     <= du_next;
            c_status_reg <= b_rec_reg.status;
            c_seq_reg    <= b_rec_reg.sequence_number;
        end
    end

    // Stage D: scale seconds to microseconds, wrapping to 32 bits; zero unless accepted.
    logic [31:0] trip_next;
    logic [31:0] d_trip_reg;
    status_t     d_status_reg;
    logic [15:0] d_seq_reg;

    assign trip_next = (c_status_reg == STAT_OK) ? c_ds_reg * USEC_PER_SEC + c_du_reg
                                                 : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_adv) begin
            d_trip_reg   <= trip_next;
            d_status_reg <= c_status_reg;
            d_seq_reg    <= c_seq_reg;
        end
    end

    // Output stage: statistics registers double as the result payload.
    logic [31:0] count_reg, count_next;
    logic [31:0] rtt_min_reg, rtt_min_next;
    logic [31:0] rtt_max_reg, rtt_max_next;
    logic [47:0] rtt_sum_reg, rtt_sum_next;
    logic [31:0] o_trip_reg;
    status_t     o_status_reg;
    logic [15:0] o_seq_reg;
    logic        stats_load;

    always_comb begin
        stats_load   = o_adv && d_valid_reg && (d_status_reg == STAT_OK);
        count_next   = count_reg + 32'd1;
        rtt_sum_next = rtt_sum_reg + {{16{d_trip_reg[31]}}, d_trip_reg};
        rtt_min_next = ($signed(d_trip_reg) < $signed(rtt_min_reg)) ? d_trip_reg : rtt_min_reg;
        rtt_max_next = ($signed(d_trip_reg) > $signed(rtt_max_reg)) ? d_trip_reg : rtt_max_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            count_reg   <= 32'd0;
            rtt_min_reg <= TRIP_MIN_RESET;
            rtt_max_reg <= 32'd0;
            rtt_sum_reg <= 48'd0;
        end else begin
            if (o_adv) begin
                o_valid_reg <= d_valid_reg;
            end
            if (stats_load) begin
                count_reg   <= count_next;
                rtt_min_reg <= rtt_min_next;
                rtt_max_reg <= rtt_max_next;
                rtt_sum_reg <= rtt_sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (o_adv && d_valid_reg) begin
            o_trip_reg   <= d_trip_reg;
            o_status_reg <= d_status_reg;
            o_seq_reg    <= d_seq_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {rtt_sum_reg, rtt_max_reg, rtt_min_reg, count_reg,
                       o_seq_reg, o_trip_reg};

endmodule
